[rtl/core/sha256_pkg.sv]
// ----------------------------------------------------------------------------
// sha256_pkg
// constants and round functions shared by the stream hasher
// ----------------------------------------------------------------------------
`default_nettype none

package sha256_pkg;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;

  localparam logic [31:0] INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef logic [31:0] word_t;

  function automatic word_t ror(input word_t v, input int unsigned n);
    return (v >> n) | (v << (32 - n));
  endfunction

  function automatic word_t ssig0(input word_t v);
    return ror(v, 7) ^ ror(v, 18) ^ (v >> 3);
  endfunction

  function automatic word_t ssig1(input word_t v);
    return ror(v, 17) ^ ror(v, 19) ^ (v >> 10);
  endfunction

  function automatic word_t bsig0(input word_t v);
    return ror(v, 2) ^ ror(v, 13) ^ ror(v, 22);
  endfunction

  function automatic word_t bsig1(input word_t v);
    return ror(v, 6) ^ ror(v, 11) ^ ror(v, 25);
  endfunction

endpackage

`default_nettype wire

[rtl/core/sha256_stream_hasher_unit.sv]
// ----------------------------------------------------------------------------
// sha256_stream_hasher_unit
// byte-serial sha-256 hasher with the message block held in a word memory
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid/in_stall, kind, data_byte): kind 0 absorbs one
//   message byte, kind 1 finishes the message. output channel
//   (out_valid/out_stall): eight transactions carrying digest_word,
//   word_index 0..7 and last_word on the eighth.
//   an absorb takes one byte; the 64th byte of a block also runs the
//   compression: a step to issue the first block memory read, a step to
//   load the first word, then 64 rounds at one round per cycle, plus a
//   fold step. the input stalls until the fold is done.
//   a finish sweeps the padding one byte per cycle, runs the compression
//   and a second sweep plus compression when fewer than 9 bytes were
//   free. out_valid is set by the fold of the last block, then eight
//   output transactions follow, one per cycle when not stalled.
//   the chaining words are re-seeded after the last word.
//   reset (rst, synchronous) restores the initial hash and clears the
//   counters. while the receiver stalls the current digest word is held and
//   no new transaction is taken on the input.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_stream_hasher_unit (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   in_valid,
  output logic                  in_stall,
  input  wire                   kind,
  input  wire  [7:0]            data_byte,
  output logic                  out_valid,
  input  wire                   out_stall,
  output sha256_pkg::word_t     digest_word,
  output logic [2:0]            word_index,
  output logic                  last_word
);
  import sha256_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PAD  = 3'd1;
  localparam logic [2:0] ST_RND  = 3'd2;
  localparam logic [2:0] ST_FOLD = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0]  state;
  logic [5:0]  fill_count;
  logic [60:0] byte_count;
  logic        finishing;
  logic        last_block;
  logic        pad_first;
  logic [6:0]  step;
  logic [2:0]  out_idx;
  logic [23:0] word_acc;
  word_t       chain [8];
  word_t       s [8];

  // schedule window, w_win[15] holds the word of the current round
  word_t       w_win [16];

  // block memory as 16 words; bytes merged into an accumulator first
  word_t       blk_mem [16];
  word_t       blk_rd;
  logic [3:0]  blk_ra;
  logic        blk_we;
  logic [3:0]  blk_wa;
  word_t       blk_wd;

  logic        acc_in;
  logic        pad_in;
  logic [7:0]  pad_byte;
  logic [2:0]  len_sel;
  logic [63:0] bits;
  word_t       w_next;
  word_t       t1;
  word_t       t2;

  always_ff @(posedge clk) begin
    if (blk_we) blk_mem[blk_wa] <= blk_wd;
    blk_rd <= blk_mem[blk_ra];
  end

  assign in_stall = (state != ST_IDLE);
  assign acc_in   = (state == ST_IDLE) && in_valid && !in_stall && !kind;
  assign pad_in   = (state == ST_PAD);
  assign bits     = {byte_count, 3'b000};
  assign len_sel  = 3'd7 - fill_count[2:0];

  // 0x80 first, then zeros, length field only in the final block
  always_comb begin
    if (pad_first) pad_byte = PAD_BYTE;
    else if (last_block && fill_count >= LEN_POS) pad_byte = bits[{len_sel, 3'b000} +: 8];
    else pad_byte = 8'h00;
  end

  assign blk_we = (acc_in || pad_in) && (fill_count[1:0] == 2'd3);
  assign blk_wa = fill_count[5:2];
  assign blk_wd = {word_acc, acc_in ? data_byte : pad_byte};
  assign blk_ra = step[3:0];

  // next schedule word, prepared one round ahead
  always_comb begin
    if (step <= 7'd16) w_next = blk_rd;
    else w_next = w_win[0] + ssig0(w_win[1]) + w_win[9] + ssig1(w_win[14]);
  end

  always_comb begin
    t1 = s[7] + bsig1(s[4]) + ((s[4] & s[5]) ^ (~s[4] & s[6])) +
         ROUND_K[6'(step - 7'd2)] + w_win[15];
    t2 = bsig0(s[0]) + ((s[0] & s[1]) ^ (s[0] & s[2]) ^ (s[1] & s[2]));
  end

  always_ff @(posedge clk) begin
    if (acc_in) word_acc <= {word_acc[15:0], data_byte};
    else if (pad_in) word_acc <= {word_acc[15:0], pad_byte};
    if (state == ST_RND) begin
      if (step == 7'd0) begin
        for (int i = 0; i < 8; i++) s[i] <= chain[i];
      end else begin
        for (int i = 0; i < 15; i++) w_win[i] <= w_win[i + 1];
        w_win[15] <= w_next;
        if (step >= 7'd2) begin
          s[7] <= s[6]; s[6] <= s[5]; s[5] <= s[4]; s[4] <= s[3] + t1;
          s[3] <= s[2]; s[2] <= s[1]; s[1] <= s[0]; s[0] <= t1 + t2;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      fill_count <= '0;
      byte_count <= '0;
      finishing  <= 1'b0;
      last_block <= 1'b0;
      pad_first  <= 1'b0;
      step       <= '0;
      out_idx    <= '0;
      out_valid  <= 1'b0;
      for (int i = 0; i < 8; i++) chain[i] <= INIT_HASH[i];
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid && !in_stall) begin
            if (!kind) begin
              fill_count <= fill_count + 6'd1;
              byte_count <= byte_count + 61'd1;
              if (fill_count == 6'd63) begin
                state <= ST_RND;
                step  <= '0;
              end
            end else begin
              finishing  <= 1'b1;
              last_block <= (fill_count < LEN_POS);
              pad_first  <= 1'b1;
              state      <= ST_PAD;
            end
          end
        end
        ST_PAD: begin
          fill_count <= fill_count + 6'd1;
          pad_first  <= 1'b0;
          if (fill_count == 6'd63) begin
            state <= ST_RND;
            step  <= '0;
          end
        end
        ST_RND: begin
          // step 0 issues the first read, step 1 loads it, 2..65 are rounds
          step <= step + 7'd1;
          if (step == 7'd65) state <= ST_FOLD;
        end
        ST_FOLD: begin
          for (int i = 0; i < 8; i++) chain[i] <= chain[i] + s[i];
          step <= '0;
          if (!finishing) state <= ST_IDLE;
          else if (!last_block) begin
            last_block <= 1'b1;
            state      <= ST_PAD;
          end else begin
            state     <= ST_OUT;
            out_idx   <= '0;
            out_valid <= 1'b1;
          end
        end
        ST_OUT: begin
          if (!out_stall) begin
            out_idx <= out_idx + 3'd1;
            if (out_idx == 3'd7) begin
              out_valid  <= 1'b0;
              finishing  <= 1'b0;
              last_block <= 1'b0;
              fill_count <= '0;
              byte_count <= '0;
              state      <= ST_IDLE;
              for (int i = 0; i < 8; i++) chain[i] <= INIT_HASH[i];
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign digest_word = chain[out_idx];
  assign word_index  = out_idx;
  assign last_word   = (out_idx == 3'd7);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(digest_word) && $stable(word_index))
    else $error("digest transaction changed while stalled");

  a_out_state: assert property (@(posedge clk) disable iff (rst)
    out_valid == (state == ST_OUT))
    else $error("out_valid outside output phase");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RND) |-> (step <= 7'd65))
    else $error("round step out of range");

  a_fill_aligned: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RND || state == ST_FOLD) |-> (fill_count == 6'd0))
    else $error("compression started on a partial block");

endmodule

`default_nettype wire

[dv/tb_sha256_stream_hasher_unit.sv]
// ----------------------------------------------------------------------------
// tb_sha256_stream_hasher_unit
// streams messages of random length and content into the hasher, computes
// each digest in a local sha-256 predictor and compares the eight digest
// words, under several sender and receiver idling phases
// ----------------------------------------------------------------------------
module tb_sha256_stream_hasher_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import sha256_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_beat_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic        kind;
  logic [7:0]  data_byte;
  logic        out_valid;
  logic        out_stall;
  word_t       digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  sha256_stream_hasher_unit u_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .kind(kind), .data_byte(data_byte), .out_valid(out_valid),
    .out_stall(out_stall), .digest_word(digest_word),
    .word_index(word_index), .last_word(last_word)
  );

  // predictor state
  logic [31:0] hash_state [8];
  logic [7:0]  msg_block [64];
  int          block_fill;
  logic [60:0] msg_bytes;

  digest_beat_t digest_q [$];
  int  send_idle_pct;
  int  recv_stall_pct;
  bit  hold_off;
  int  mismatches;
  int  idle_cycles;
  bit  timed_out;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  function automatic logic [31:0] rotr(logic [31:0] v, int n);
    return (v >> n) | (v << (32 - n));
  endfunction

  task automatic compress_block();
    logic [31:0] w [64];
    logic [31:0] s [8];
    logic [31:0] t1, t2, e, a, sg0, sg1;
    for (int j = 0; j < 16; j++)
      w[j] = {msg_block[4*j], msg_block[4*j+1], msg_block[4*j+2], msg_block[4*j+3]};
    for (int r = 16; r < 64; r++) begin
      sg0 = rotr(w[r-15], 7) ^ rotr(w[r-15], 18) ^ (w[r-15] >> 3);
      sg1 = rotr(w[r-2], 17) ^ rotr(w[r-2], 19) ^ (w[r-2] >> 10);
      w[r] = w[r-16] + sg0 + w[r-7] + sg1;
    end
    for (int j = 0; j < 8; j++) s[j] = hash_state[j];
    for (int r = 0; r < 64; r++) begin
      e = s[4];
      a = s[0];
      t1 = s[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & s[5]) ^ (~e & s[6]))
           + ROUND_K[r] + w[r];
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & s[1]) ^ (a & s[2]) ^ (s[1] & s[2]));
      s[7] = s[6]; s[6] = s[5]; s[5] = s[4]; s[4] = s[3] + t1;
      s[3] = s[2]; s[2] = s[1]; s[1] = s[0]; s[0] = t1 + t2;
    end
    for (int j = 0; j < 8; j++) hash_state[j] = hash_state[j] + s[j];
  endtask

  task automatic restart_hash();
    for (int j = 0; j < 8; j++) hash_state[j] = INIT_HASH[j];
    block_fill = 0;
    msg_bytes  = '0;
  endtask

  task automatic predict_digest(logic k, logic [7:0] b);
    logic [63:0] bit_len;
    int pos;
    digest_beat_t beat;
    if (!k) begin
      msg_block[block_fill] = b;
      block_fill++;
      msg_bytes++;
      if (block_fill == 64) begin
        compress_block();
        block_fill = 0;
      end
    end else begin
      bit_len = {msg_bytes, 3'b000};
      pos = block_fill;
      msg_block[pos] = PAD_BYTE;
      pos++;
      if (pos > LEN_POS) begin
        while (pos < 64) begin msg_block[pos] = 8'h00; pos++; end
        compress_block();
        pos = 0;
      end
      while (pos < LEN_POS) begin msg_block[pos] = 8'h00; pos++; end
      for (int j = 0; j < 8; j++) msg_block[LEN_POS + j] = bit_len[63 - 8*j -: 8];
      compress_block();
      for (int j = 0; j < 8; j++) begin
        beat.word = hash_state[j];
        beat.idx  = j[2:0];
        beat.last = (j == 7);
        digest_q.push_back(beat);
      end
      restart_hash();
    end
  endtask

  task automatic send_item(logic k, logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    kind      <= k;
    data_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_digest(k, b);
  endtask

  task automatic send_message(int len);
    for (int i = 0; i < len; i++) send_item(1'b0, 8'($urandom));
    send_item(1'b1, 8'($urandom));
  endtask

  // rough message length: mostly short, some around block boundaries
  function automatic int pick_len();
    int sel;
    sel = $urandom_range(9);
    if (sel < 5) return $urandom_range(20);
    if (sel < 8) return $urandom_range(50, 70);
    return $urandom_range(110, 130);
  endfunction

  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (digest_q.size() != 0 && !timed_out) @(posedge clk);
  endtask

  // receiver stall generator
  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
  end

  // result checker
  always @(posedge clk) begin
    digest_beat_t exp_beat;
    if (!rst && out_valid && !out_stall) begin
      if (digest_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected transaction word=%h idx=%0d last=%0b",
                   digest_word, word_index, last_word);
      end else begin
        exp_beat = digest_q.pop_front();
        if (digest_word !== exp_beat.word || word_index !== exp_beat.idx ||
            last_word !== exp_beat.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp word=%h idx=%0d last=%0b act word=%h idx=%0d last=%0b",
                     exp_beat.word, exp_beat.idx, exp_beat.last,
                     digest_word, word_index, last_word);
        end
      end
    end
  end

  // watchdog on cycles without any accepted transaction
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("FAIL sha256_stream_hasher_unit");
      $finish;
    end
  end

  task automatic test_directed();
    send_item(1'b1, 8'hff);              // empty message, data ignored
    send_message(0);
    send_item(1'b0, 8'h61); send_item(1'b0, 8'h62); send_item(1'b0, 8'h63);
    send_item(1'b1, 8'h00);              // "abc"
    for (int i = 0; i < 5; i++) send_item(1'b0, (i % 2) ? 8'h00 : 8'hff);
    send_item(1'b1, 8'h55);
    wait_drain();
  endtask

  task automatic test_boundaries();
    // lengths that put the pad byte near the length field and the block end
    int lens [4] = '{55, 56, 63, 64};
    foreach (lens[i]) send_message(lens[i]);
    wait_drain();
  endtask

  task automatic test_random(int n_items);
    int sent, len;
    sent = 0;
    while (sent < n_items) begin
      len = pick_len();
      if (len > n_items - sent - 1) len = n_items - sent - 1;
      send_message(len);
      sent += len + 1;
    end
    wait_drain();
  endtask

  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    fork
      begin
        hold_off = 1'b1;
        repeat (600) @(posedge clk);
        hold_off = 1'b0;
      end
      begin
        for (int m = 0; m < 4; m++) send_message($urandom_range(3));
      end
    join
    wait_drain();
  endtask

  initial begin
    rst = 1'b1; in_valid = 1'b0; kind = 1'b0; data_byte = 8'h00;
    send_idle_pct = 0; recv_stall_pct = 0; hold_off = 1'b0;
    restart_hash();
    for (int j = 0; j < 64; j++) msg_block[j] = 8'h00;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_boundaries();
    send_idle_pct = 0;  recv_stall_pct = 0;  test_random(40);
    send_idle_pct = 78; recv_stall_pct = 0;  test_random(30);
    send_idle_pct = 0;  recv_stall_pct = 78; test_random(30);
    send_idle_pct = 15; recv_stall_pct = 15; test_random(30);
    test_backpressure();
    send_idle_pct = 0;  recv_stall_pct = 0;  test_random(10);

    repeat (200) @(posedge clk);
    if (mismatches == 0 && digest_q.size() == 0)
      $display("PASS sha256_stream_hasher_unit");
    else
      $display("FAIL sha256_stream_hasher_unit");
    $finish;
  end

endmodule
